// ----- design/i2cbe_pkg.sv -----
// i2cbe_pkg: shared types, request codes and phase counts of the i2c master byte engine
// no dependencies; imported by i2cbe_step, i2c_master_byte_engine_core and the testbench
package i2cbe_pkg;

    // request codes
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;
    localparam logic [2:0] REQ_INIT  = 3'd5;

    // idle value of the active command
    localparam logic [2:0] CMD_IDLE = 3'd0;

    // phases of each command
    localparam logic [4:0] PH_CNT_INIT  = 5'd1;
    localparam logic [4:0] PH_CNT_START = 5'd3;
    localparam logic [4:0] PH_CNT_STOP  = 5'd3;
    localparam logic [4:0] PH_CNT_WRITE = 5'd27;
    localparam logic [4:0] PH_CNT_READ  = 5'd19;

    // write byte landmarks
    localparam logic [4:0] PH_WR_ACK_REL = 5'd24;
    localparam logic [4:0] PH_WR_ACK_SCL = 5'd25;

    // read byte landmarks
    localparam logic [4:0] PH_RD_ACK_DRV = 5'd16;
    localparam logic [4:0] PH_RD_ACK_SCL = 5'd17;

    // position inside one written bit (phase mod 3)
    localparam logic [1:0] SUB_DATA = 2'd0;
    localparam logic [1:0] SUB_SCLH = 2'd1;
    localparam logic [1:0] SUB_SCLL = 2'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       rd_ack_en;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] rx_byte;
        logic       rejected;
    } t_out_item;

    typedef struct packed {
        logic [4:0] phase;
        logic [2:0] cmd;
        logic [1:0] sub;
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       ack_flag;
        logic       ack_mode;
    } t_state;

    // number of phases of a command
    function automatic logic [4:0] phase_count(input logic [2:0] cmd);
        logic [4:0] cnt;
        case (cmd)
            REQ_START: cnt = PH_CNT_START;
            REQ_STOP:  cnt = PH_CNT_STOP;
            REQ_WRITE: cnt = PH_CNT_WRITE;
            REQ_READ:  cnt = PH_CNT_READ;
            REQ_INIT:  cnt = PH_CNT_INIT;
            default:   cnt = PH_CNT_INIT;
        endcase
        return cnt;
    endfunction

endpackage

// ----- design/i2cbe_step.sv -----
// i2cbe_step: next state and result of one request beat, purely combinational
// depends on i2cbe_pkg
module i2cbe_step (
    input  i2cbe_pkg::t_state    i_state,
    input  i2cbe_pkg::t_in_item  i_item,
    output i2cbe_pkg::t_state    o_state,
    output i2cbe_pkg::t_out_item o_item
);
    import i2cbe_pkg::*;

    t_state     n;
    logic       ap_en;
    logic [2:0] ap_cmd;
    logic [4:0] ap_p;
    logic [4:0] p_next;
    logic       done;
    logic       ack_out;
    logic [7:0] rx_out;
    logic       rej;

    assign p_next = i_state.phase + 5'd1;

    always_comb begin
        n       = i_state;
        ap_en   = 1'b0;
        ap_cmd  = i_state.cmd;
        ap_p    = 5'd0;
        done    = 1'b0;
        ack_out = 1'b0;
        rx_out  = 8'd0;
        rej     = 1'b0;

        // command or tick handling
        if (i_item.req_type inside {[REQ_START:REQ_INIT]}) begin
            if (i_state.cmd != CMD_IDLE) begin
                rej = 1'b1;
            end else begin
                n.cmd      = i_item.req_type;
                n.phase    = 5'd0;
                n.sub      = SUB_DATA;
                n.ack_flag = 1'b0;
                if (i_item.req_type == REQ_WRITE) begin
                    n.shift = i_item.tx_byte;
                end else if (i_item.req_type == REQ_READ) begin
                    n.shift    = 8'd0;
                    n.ack_mode = i_item.rd_ack_en;
                end
                ap_en  = 1'b1;
                ap_cmd = i_item.req_type;
                ap_p   = 5'd0;
            end
        end else if (i_item.req_type == REQ_TICK && i_state.cmd != CMD_IDLE) begin
            // ack sample at end of the high ack clock
            if (i_state.cmd == REQ_WRITE && i_state.phase == PH_WR_ACK_SCL) begin
                n.ack_flag = ~i_item.sda_in;
            end
            // data sample at end of each high read clock
            if (i_state.cmd == REQ_READ && i_state.phase < PH_RD_ACK_DRV
                    && !i_state.phase[0]) begin
                n.shift = {i_state.shift[6:0], i_item.sda_in};
            end
            n.sub = (i_state.sub == SUB_SCLL) ? SUB_DATA : i_state.sub + 2'd1;
            if (p_next >= phase_count(i_state.cmd)) begin
                done = 1'b1;
                if (i_state.cmd == REQ_WRITE) begin
                    ack_out = n.ack_flag;
                end
                if (i_state.cmd == REQ_READ) begin
                    rx_out = n.shift;
                    n.sda  = 1'b0;
                end
                n.cmd   = CMD_IDLE;
                n.phase = 5'd0;
            end else begin
                n.phase = p_next;
                ap_en   = 1'b1;
                ap_p    = p_next;
            end
        end

        // line drives of the phase that begins now
        if (ap_en) begin
            case (ap_cmd)
                REQ_INIT: begin
                    n.sda = 1'b0;
                    n.scl = 1'b0;
                end
                REQ_START: begin
                    if (ap_p == 5'd0) begin
                        n.sda = 1'b0;
                        n.scl = 1'b0;
                    end else if (ap_p == 5'd1) begin
                        n.sda = 1'b1;
                    end else begin
                        n.scl = 1'b1;
                    end
                end
                REQ_STOP: begin
                    if (ap_p == 5'd0) begin
                        n.sda = 1'b1;
                    end else if (ap_p == 5'd1) begin
                        n.scl = 1'b0;
                    end else begin
                        n.sda = 1'b0;
                    end
                end
                REQ_WRITE: begin
                    if (ap_p < PH_WR_ACK_REL) begin
                        case (n.sub)
                            SUB_DATA: n.sda = ~n.shift[7];
                            SUB_SCLH: n.scl = 1'b0;
                            default: begin
                                n.scl   = 1'b1;
                                n.shift = {n.shift[6:0], 1'b0};
                            end
                        endcase
                    end else if (ap_p == PH_WR_ACK_REL) begin
                        n.sda = 1'b0;
                    end else if (ap_p == PH_WR_ACK_SCL) begin
                        n.scl = 1'b0;
                    end else begin
                        n.scl = 1'b1;
                    end
                end
                REQ_READ: begin
                    if (ap_p < PH_RD_ACK_DRV) begin
                        if (ap_p == 5'd0) begin
                            n.sda = 1'b0;
                        end
                        n.scl = ap_p[0];
                    end else if (ap_p == PH_RD_ACK_DRV) begin
                        n.sda = n.ack_mode;
                    end else if (ap_p == PH_RD_ACK_SCL) begin
                        n.scl = 1'b0;
                    end else begin
                        n.scl = 1'b1;
                    end
                end
                default: begin
                    n.scl = n.scl;
                end
            endcase
        end
    end

    assign o_state         = n;
    assign o_item.scl_low  = n.scl;
    assign o_item.sda_low  = n.sda;
    assign o_item.busy_res = (n.cmd != CMD_IDLE);
    assign o_item.done_res = done;
    assign o_item.ack_ok   = ack_out;
    assign o_item.rx_byte  = rx_out;
    assign o_item.rejected = rej;

endmodule

// ----- design/i2c_master_byte_engine_core.sv -----
// i2c_master_byte_engine_core: top level, engine state register and result register
// depends on i2cbe_pkg and i2cbe_step
// a result beat is registered and offered in the cycle after its request beat is accepted
// throughput: one request beat per cycle unless the receiver stalls; the single step of logic sets the pace
// the result register frees in the cycle it is taken, so input keeps flowing
// reset: synchronous active-low i_rst_n clears engine state to idle, lines released
module i2c_master_byte_engine_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  i2cbe_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output i2cbe_pkg::t_out_item o_out_item
);
    import i2cbe_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      r_out_valid;
    logic      in_fire;

    // accept while the result slot is empty or being emptied
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    i2cbe_step u_step (
        .i_state (r_state),
        .i_item  (i_in_item),
        .o_state (n_state),
        .o_item  (n_out_item)
    );

    // engine state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // an accepted beat always shows up in the result register
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out_valid)
        else $error("accepted beat produced no result");

    // a finished command leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |-> !o_out_item.busy_res)
        else $error("done reported while still busy");

    // rejection and completion are exclusive
    a_rej_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.rejected && o_out_item.done_res))
        else $error("rejected and done in one result");

    // phase index stays inside the active command
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.cmd != CMD_IDLE) |-> (r_state.phase < phase_count(r_state.cmd)))
        else $error("phase index beyond command length");

    // busy flag tracks the engine state
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.busy_res == (r_state.cmd != CMD_IDLE)))
        else $error("busy flag disagrees with engine state");

endmodule

// ----- verif/i2c_master_byte_engine_core_tb.sv -----
// i2c_master_byte_engine_core_tb: self-checking testbench of the i2c master byte engine core
// depends on i2cbe_pkg and the design under design/; own line-level predictor, no files read
module i2c_master_byte_engine_core_tb;
    import i2cbe_pkg::*;

    // request codes the engine ignores
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    // sda levels a slave presents during one command
    localparam int SLAVE_ALL_LOW  = 0;
    localparam int SLAVE_ALL_HIGH = 1;
    localparam int SLAVE_RANDOM   = 2;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // predicted engine state
    logic [4:0] eng_phase;
    logic [2:0] eng_cmd;
    logic [7:0] eng_shift;
    logic       eng_scl;
    logic       eng_sda;
    logic       eng_ack_flag;
    logic       eng_ack_mode;

    t_out_item exp_status_q[$];
    int        fail_count = 0;
    int        in_idle_pct = 0;
    int        out_stall_pct = 0;
    int        slave_mode = SLAVE_RANDOM;

    i2c_master_byte_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // line drives applied when a phase begins
    function automatic void drive_phase(input logic [2:0] cmd, input logic [4:0] p);
        logic [1:0] sub;
        sub = 2'(p % 5'd3);
        case (cmd)
            REQ_INIT: begin
                eng_sda = 1'b0;
                eng_scl = 1'b0;
            end
            REQ_START: begin
                if (p == 5'd0) begin
                    eng_sda = 1'b0;
                    eng_scl = 1'b0;
                end else if (p == 5'd1) begin
                    eng_sda = 1'b1;
                end else begin
                    eng_scl = 1'b1;
                end
            end
            REQ_STOP: begin
                if (p == 5'd0) eng_sda = 1'b1;
                else if (p == 5'd1) eng_scl = 1'b0;
                else eng_sda = 1'b0;
            end
            REQ_WRITE: begin
                if (p < PH_WR_ACK_REL) begin
                    case (sub)
                        SUB_DATA: eng_sda = ~eng_shift[7];
                        SUB_SCLH: eng_scl = 1'b0;
                        default: begin
                            eng_scl   = 1'b1;
                            eng_shift = {eng_shift[6:0], 1'b0};
                        end
                    endcase
                end else if (p == PH_WR_ACK_REL) begin
                    eng_sda = 1'b0;
                end else if (p == PH_WR_ACK_SCL) begin
                    eng_scl = 1'b0;
                end else begin
                    eng_scl = 1'b1;
                end
            end
            REQ_READ: begin
                if (p < PH_RD_ACK_DRV) begin
                    if (p == 5'd0) eng_sda = 1'b0;
                    eng_scl = p[0];
                end else if (p == PH_RD_ACK_DRV) begin
                    eng_sda = eng_ack_mode;
                end else if (p == PH_RD_ACK_SCL) begin
                    eng_scl = 1'b0;
                end else begin
                    eng_scl = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // advance the predicted engine by one request beat
    function automatic t_out_item engine_step(input t_in_item it);
        t_out_item  r;
        logic [4:0] nxt;
        logic [4:0] last;
        r = '0;
        if (it.req_type >= REQ_START && it.req_type <= REQ_INIT) begin
            if (eng_cmd != CMD_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                eng_cmd      = it.req_type;
                eng_phase    = '0;
                eng_ack_flag = 1'b0;
                if (it.req_type == REQ_WRITE) begin
                    eng_shift = it.tx_byte;
                end else if (it.req_type == REQ_READ) begin
                    eng_shift    = '0;
                    eng_ack_mode = it.rd_ack_en;
                end
                drive_phase(it.req_type, 5'd0);
            end
        end else if (it.req_type == REQ_TICK && eng_cmd != CMD_IDLE) begin
            // samples taken at the end of a phase
            if (eng_cmd == REQ_WRITE && eng_phase == PH_WR_ACK_SCL)
                eng_ack_flag = ~it.sda_in;
            if (eng_cmd == REQ_READ && eng_phase < PH_RD_ACK_DRV && !eng_phase[0])
                eng_shift = {eng_shift[6:0], it.sda_in};
            case (eng_cmd)
                REQ_START: last = PH_CNT_START;
                REQ_STOP:  last = PH_CNT_STOP;
                REQ_WRITE: last = PH_CNT_WRITE;
                REQ_READ:  last = PH_CNT_READ;
                default:   last = PH_CNT_INIT;
            endcase
            nxt = eng_phase + 5'd1;
            if (nxt >= last) begin
                r.done_res = 1'b1;
                if (eng_cmd == REQ_WRITE) r.ack_ok = eng_ack_flag;
                if (eng_cmd == REQ_READ) begin
                    r.rx_byte = eng_shift;
                    eng_sda   = 1'b0;
                end
                eng_cmd   = CMD_IDLE;
                eng_phase = '0;
            end else begin
                eng_phase = nxt;
                drive_phase(eng_cmd, nxt);
            end
        end
        r.scl_low  = eng_scl;
        r.sda_low  = eng_sda;
        r.busy_res = (eng_cmd != CMD_IDLE);
        return r;
    endfunction

    function automatic t_in_item make_req(input logic [2:0] req, input logic [7:0] tx,
                                          input logic ack, input logic sda);
        t_in_item it;
        it.req_type  = req;
        it.tx_byte   = tx;
        it.rd_ack_en = ack;
        it.sda_in    = sda;
        return it;
    endfunction

    // one request beat, with random idle cycles ahead of it
    task automatic send_req(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        exp_status_q.push_back(engine_step(it));
    endtask

    // hold off requests until every predicted beat has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (exp_status_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result beat check and random receiver stall
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_status_q.size() == 0) begin
                $error("result beat with no expected result pending");
                fail_count++;
            end else begin
                want = exp_status_q.pop_front();
                check_field("scl_low",  8'(want.scl_low),  8'(o_out_item.scl_low));
                check_field("sda_low",  8'(want.sda_low),  8'(o_out_item.sda_low));
                check_field("busy_res", 8'(want.busy_res), 8'(o_out_item.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(o_out_item.done_res));
                check_field("ack_ok",   8'(want.ack_ok),   8'(o_out_item.ack_ok));
                check_field("rx_byte",  want.rx_byte,      o_out_item.rx_byte);
                check_field("rejected", 8'(want.rejected), 8'(o_out_item.rejected));
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // ticks and unused codes while idle change nothing
    task automatic test_idle_requests();
        send_req(make_req(REQ_TICK, 8'hFF, 1'b1, 1'b1));
        send_req(make_req(REQ_UNUSED_LO, 8'h00, 1'b0, 1'b0));
        send_req(make_req(REQ_UNUSED_HI, 8'hFF, 1'b1, 1'b1));
        send_req(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0));
    endtask

    // short commands run to done
    task automatic test_init_start_stop();
        send_req(make_req(REQ_INIT, 8'h00, 1'b0, 1'b1));
        send_req(make_req(REQ_TICK, 8'h00, 1'b0, 1'b1));
        send_req(make_req(REQ_START, 8'hFF, 1'b1, 1'b1));
        repeat (3) send_req(make_req(REQ_TICK, 8'h00, 1'b0, 1'b1));
        send_req(make_req(REQ_STOP, 8'h00, 1'b0, 1'b0));
        repeat (3) send_req(make_req(REQ_TICK, 8'hFF, 1'b1, 1'b0));
    endtask

    // commands while busy are rejected, unused codes ignored, ticks advance the active command
    task automatic test_busy_rejection();
        send_req(make_req(REQ_INIT, 8'h00, 1'b0, 1'b0));
        send_req(make_req(REQ_WRITE, 8'hFF, 1'b1, 1'b1));
        send_req(make_req(REQ_READ, 8'h00, 1'b1, 1'b0));
        send_req(make_req(REQ_UNUSED_HI, 8'hA5, 1'b0, 1'b1));
        send_req(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0));
        send_req(make_req(REQ_START, 8'h00, 1'b0, 1'b0));
        send_req(make_req(REQ_STOP, 8'h00, 1'b0, 1'b0));
        send_req(make_req(REQ_INIT, 8'h00, 1'b0, 1'b0));
        repeat (3) send_req(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0));
    endtask

    // mostly complete command sequences with random content, some noise
    task automatic run_random_traffic(input int n_beats);
        t_in_item it;
        int       counted;
        int       pick;
        counted = 0;
        while (counted < n_beats) begin
            it.req_type = REQ_TICK;
            case ($urandom_range(3))
                0:       it.tx_byte = 8'h00;
                1:       it.tx_byte = 8'hFF;
                default: it.tx_byte = 8'($urandom);
            endcase
            it.rd_ack_en = 1'($urandom);
            pick = $urandom_range(99);
            if (eng_cmd != CMD_IDLE) begin
                // busy: ticks with slave data, sometimes a stray command
                if (pick < 92) begin
                    it.req_type = REQ_TICK;
                    counted++;
                end else if (pick < 97) begin
                    it.req_type = 3'($urandom_range(REQ_START, REQ_INIT));
                end else begin
                    it.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                end
                case (slave_mode)
                    SLAVE_ALL_LOW:  it.sda_in = 1'b0;
                    SLAVE_ALL_HIGH: it.sda_in = 1'b1;
                    default:        it.sda_in = 1'($urandom);
                endcase
            end else begin
                // idle: start a new command most of the time
                it.sda_in = 1'($urandom);
                if (pick < 30) it.req_type = REQ_WRITE;
                else if (pick < 60) it.req_type = REQ_READ;
                else if (pick < 70) it.req_type = REQ_START;
                else if (pick < 80) it.req_type = REQ_STOP;
                else if (pick < 86) it.req_type = REQ_INIT;
                else if (pick < 93) it.req_type = REQ_TICK;
                else it.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                if (it.req_type >= REQ_START && it.req_type <= REQ_INIT) begin
                    counted++;
                    slave_mode = $urandom_range(SLAVE_ALL_LOW, SLAVE_RANDOM);
                end
            end
            send_req(it);
        end
    endtask

    task automatic test_random_sender_idle();
        in_idle_pct   = 33;
        out_stall_pct = 63;
        run_random_traffic(150);
        wait_results_drained();
    endtask

    // includes a full hold-off in the middle of traffic
    task automatic test_random_receiver_stall();
        in_idle_pct   = 63;
        out_stall_pct = 33;
        run_random_traffic(75);
        wait_results_drained();
        run_random_traffic(75);
        wait_results_drained();
    endtask

    task automatic test_random_full_rate();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random_traffic(150);
    endtask

    // main sequence
    initial begin
        int guard;
        eng_phase    = '0;
        eng_cmd      = CMD_IDLE;
        eng_shift    = '0;
        eng_scl      = 1'b0;
        eng_sda      = 1'b0;
        eng_ack_flag = 1'b0;
        eng_ack_mode = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct   = 33;
        out_stall_pct = 63;
        test_idle_requests();
        test_init_start_stop();
        test_busy_rejection();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_full_rate();

        // drain, then watch for stray beats before the final check
        i_in_valid <= 1'b0;
        guard = 0;
        while (exp_status_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (5) @(posedge i_clk);
        if (exp_status_q.size() != 0) begin
            $error("%0d expected results never arrived", exp_status_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/i2cbe_pkg.sv
design/i2cbe_step.sv
design/i2c_master_byte_engine_core.sv
verif/i2c_master_byte_engine_core_tb.sv
